[hw/rtl/lldw_pkg.sv]
package lldw_pkg;

   localparam logic [23:0] END_MARK          = 24'hffffff;
   localparam logic [23:0] MAX_PACKETS_RESET = 24'd2000000;
   localparam logic [23:0] WORD_ALIGN_MASK   = 24'hfffffc;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_WORD  = 1'b1;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_GPU   = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ABORT = 2'd3;

   typedef struct packed {
      logic        action;
      logic [23:0] start_address;
      logic [31:0] mem_word;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] read_address;
      logic [31:0] gpu_word;
      logic        last;
   } result_type;

   // Up to two results leave the walker for one input transaction.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

endpackage

[hw/rtl/lldw_walk.sv]
module lldw_walk (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  lldw_pkg::item_type       item,
   input  logic [23:0]              max_packets,
   output lldw_pkg::result_pair_type results
);
   import lldw_pkg::*;

   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_HEADER  = 2'd1;
   localparam logic [1:0] PHASE_PAYLOAD = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [23:0] node_ff, node_in;
   logic [23:0] next_node_ff, next_node_in;
   logic [7:0]  words_left_ff, words_left_in;
   logic [23:0] payload_ff, payload_in;
   logic [24:0] count_ff, count_in;
   logic [23:0] prev_ff, prev_in;
   logic [23:0] lower_ff, lower_in;
   logic [23:0] upper_ff, upper_in;

   logic [23:0] e_addr;
   logic [23:0] b_prev, b_lower, b_upper;
   logic [24:0] b_count;
   logic        over, hit, below;
   result_type  enter_res;
   logic [1:0]  enter_phase;
   logic [24:0] enter_count;
   logic [23:0] enter_prev, enter_lower, enter_upper;
   logic [23:0] pa_hdr, pa_next;
   logic [7:0]  wl_dec;

   assign pa_hdr  = node_ff + 24'd4;
   assign pa_next = payload_ff + 24'd4;
   assign wl_dec  = words_left_ff - 8'd1;

   // Entering a node: packet limit first, then the three-address loop detector.
   always_comb begin
      if (item.action == ACTION_START) begin
         b_prev  = END_MARK;
         b_lower = END_MARK;
         b_upper = END_MARK;
         b_count = '0;
         e_addr  = item.start_address;
      end else begin
         b_prev  = prev_ff;
         b_lower = lower_ff;
         b_upper = upper_ff;
         b_count = count_ff;
         e_addr  = (phase_ff == PHASE_HEADER) ? item.mem_word[23:0] : next_node_ff;
      end
      over  = b_count > {1'b0, max_packets};
      hit   = (e_addr == b_lower) || (e_addr == b_upper);
      below = e_addr < b_prev;

      enter_count = over ? b_count : b_count + 25'd1;
      enter_prev  = b_prev;
      enter_lower = b_lower;
      enter_upper = b_upper;
      enter_res   = '0;
      enter_res.last = 1'b1;
      if (over || hit) begin
         enter_res.kind = KIND_ABORT;
         enter_phase    = PHASE_IDLE;
      end else begin
         enter_res.kind         = KIND_READ;
         enter_res.read_address = e_addr & WORD_ALIGN_MASK;
         enter_phase            = PHASE_HEADER;
         enter_prev             = e_addr;
         if (below) begin
            enter_lower = e_addr;
         end else begin
            enter_upper = e_addr;
         end
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      node_in       = node_ff;
      next_node_in  = next_node_ff;
      words_left_in = words_left_ff;
      payload_in    = payload_ff;
      count_in      = count_ff;
      prev_in       = prev_ff;
      lower_in      = lower_ff;
      upper_in      = upper_ff;
      results       = '0;
      if (go) begin
         if (item.action == ACTION_START) begin
            words_left_in = '0;
            node_in       = item.start_address;
            phase_in      = enter_phase;
            count_in      = enter_count;
            prev_in       = enter_prev;
            lower_in      = enter_lower;
            upper_in      = enter_upper;
            results.count = 2'd1;
            results.first = enter_res;
         end else begin
            unique case (phase_ff)
               PHASE_HEADER: begin
                  words_left_in = item.mem_word[31:24];
                  next_node_in  = item.mem_word[23:0];
                  payload_in    = pa_hdr;
                  results.count = 2'd1;
                  if (item.mem_word[31:24] != 8'd0) begin
                     phase_in                   = PHASE_PAYLOAD;
                     results.first.kind         = KIND_READ;
                     results.first.read_address = pa_hdr & WORD_ALIGN_MASK;
                     results.first.last         = 1'b1;
                  end else if (item.mem_word[23:0] == END_MARK) begin
                     phase_in           = PHASE_IDLE;
                     results.first.kind = KIND_DONE;
                     results.first.last = 1'b1;
                  end else begin
                     node_in       = item.mem_word[23:0];
                     phase_in      = enter_phase;
                     count_in      = enter_count;
                     prev_in       = enter_prev;
                     lower_in      = enter_lower;
                     upper_in      = enter_upper;
                     results.first = enter_res;
                  end
               end
               PHASE_PAYLOAD: begin
                  results.count          = 2'd2;
                  results.first.kind     = KIND_GPU;
                  results.first.gpu_word = item.mem_word;
                  words_left_in          = wl_dec;
                  payload_in             = pa_next;
                  if (wl_dec != 8'd0) begin
                     results.second.kind         = KIND_READ;
                     results.second.read_address = pa_next & WORD_ALIGN_MASK;
                     results.second.last         = 1'b1;
                  end else if (next_node_ff == END_MARK) begin
                     phase_in            = PHASE_IDLE;
                     results.second.kind = KIND_DONE;
                     results.second.last = 1'b1;
                  end else begin
                     node_in        = next_node_ff;
                     phase_in       = enter_phase;
                     count_in       = enter_count;
                     prev_in        = enter_prev;
                     lower_in       = enter_lower;
                     upper_in       = enter_upper;
                     results.second = enter_res;
                  end
               end
               default: begin
                  // A memory word with no walk in progress is dropped.
                  results.count = 2'd0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_IDLE;
         node_ff       <= '0;
         next_node_ff  <= '0;
         words_left_ff <= '0;
         payload_ff    <= '0;
         count_ff      <= '0;
         prev_ff       <= END_MARK;
         lower_ff      <= END_MARK;
         upper_ff      <= END_MARK;
      end else begin
         phase_ff      <= phase_in;
         node_ff       <= node_in;
         next_node_ff  <= next_node_in;
         words_left_ff <= words_left_in;
         payload_ff    <= payload_in;
         count_ff      <= count_in;
         prev_ff       <= prev_in;
         lower_ff      <= lower_in;
         upper_ff      <= upper_in;
      end
   end

endmodule

[hw/rtl/lldw_rsp_queue.sv]
module lldw_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  lldw_pkg::result_pair_type push,
   input  logic                      out_ready,
   output logic                      out_valid,
   output lldw_pkg::result_type      out_result,
   output logic                      room
);
   import lldw_pkg::*;

   result_type  mem_ff [4];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic        pop;
   logic [1:0]  wr_ptr_second;

   assign out_valid     = count_ff != 3'd0;
   assign out_result    = mem_ff[rd_ptr_ff];
   assign pop           = out_valid && out_ready;
   // Room means two free entries, so a transaction with two results always fits the queue.
   assign room          = count_ff <= 3'd2;
   assign wr_ptr_second = wr_ptr_ff + 2'd1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_second] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/linked_list_dma_walker_unit.sv]
// Linked-list DMA walker for a GPU DMA channel.
// The req channel carries two kinds of transaction, chosen by req_tuser: a start
// transaction gives the first node address, and a word transaction hands back the
// memory word answering the last read request. The rsp channel returns read
// requests, payload words for the GPU, and end-of-walk or abort markers; rsp_tlast
// marks the final result caused by one req transaction.
// csr_wr_en writes the packet limit from csr_wr_data; the user must write it only
// while no transaction is in flight, as the block does not enforce this.
// A req transaction is held in an input register, decided by the walker once the
// queue has two free entries, and written to a four-entry result queue for rsp.
// One req transaction per cycle while the queue has two free entries; a payload
// word causes two results, so during payload the single rsp port sets the pace.
// The input register advances only while the queue has two free entries, so a
// stalled receiver fills the queue and then holds req_tready low; nothing is lost.
// Reset clears the walk, empties the queue and sets the packet limit to 2000000.
module linked_list_dma_walker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // start_address [23:0], mem_word [55:24]
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // read_address [23:0], gpu_word [55:24]
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);
   import lldw_pkg::*;

   logic            in_valid_ff, in_valid_in;
   item_type        in_item_ff, in_item_in;
   logic [23:0]     max_packets_ff, max_packets_in;
   logic            advance;
   logic            room;
   logic            req_accept;
   result_pair_type results;
   result_type      out_result;

   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_accept) begin
         in_valid_in              = 1'b1;
         in_item_in.action        = req_tuser;
         in_item_in.start_address = req_tdata[23:0];
         in_item_in.mem_word      = req_tdata[55:24];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      max_packets_in = csr_wr_en ? csr_wr_data : max_packets_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         max_packets_ff <= MAX_PACKETS_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         max_packets_ff <= max_packets_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   lldw_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .go          (advance),
      .item        (in_item_ff),
      .max_packets (max_packets_ff),
      .results     (results)
   );

   lldw_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (results),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_result (out_result),
      .room       (room)
   );

   assign rsp_tdata = {out_result.gpu_word, out_result.read_address};
   assign rsp_tuser = out_result.kind;
   assign rsp_tlast = out_result.last;

endmodule

[hw/rtl/lldw_checker.sv]
module lldw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import lldw_pkg::*;

   // The result queue is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result shown straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Read requests always go out word-aligned.
   a_read_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_READ |-> rsp_tdata[1:0] == 2'b00)
      else $error("unaligned read request");

   // A GPU word is always followed by another result from the same transaction.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tuser != KIND_GPU))
      else $error("last flag does not match result kind");

   a_gpu_then_more: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == KIND_GPU |=> rsp_tvalid)
      else $error("second result missing after GPU word");

endmodule

bind linked_list_dma_walker_unit lldw_checker u_lldw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[bench/walk_checker.sv]
module walk_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,   // start_address [23:0], mem_word [55:24]
   input  logic        req_tuser,   // action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,   // read_address [23:0], gpu_word [55:24]
   input  logic [1:0]  rsp_tuser,   // kind
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data,
   output int          fail_count,
   output int          pending
);
   import lldw_pkg::*;

   typedef enum logic [1:0] {
      WALK_IDLE    = 2'd0,
      WALK_HEADER  = 2'd1,
      WALK_PAYLOAD = 2'd2
   } walk_phase_type;

   result_type     walk_results[$];
   result_type     wanted;
   walk_phase_type walk_phase;
   logic [23:0]    packet_limit;
   logic [23:0]    node_addr;
   logic [23:0]    next_addr;
   logic [23:0]    payload_addr;
   logic [23:0]    prev_node;
   logic [23:0]    low_seen;
   logic [23:0]    high_seen;
   logic [7:0]     words_left;
   logic [24:0]    headers_done;

   task automatic queue_result(input logic [1:0] kind, input logic [23:0] addr,
                               input logic [31:0] word, input logic last);
      result_type r;
      r.kind         = kind;
      r.read_address = addr;
      r.gpu_word     = word;
      r.last         = last;
      walk_results.push_back(r);
   endtask

   // The limit test comes first; the loop detector is only consulted when it passes.
   task automatic visit_node();
      logic over;
      logic revisit;
      over    = headers_done > {1'b0, packet_limit};
      revisit = 1'b0;
      if (!over) begin
         headers_done = headers_done + 25'd1;
         if (node_addr == low_seen || node_addr == high_seen) begin
            revisit = 1'b1;
         end else begin
            if (node_addr < prev_node) begin
               low_seen = node_addr;
            end else begin
               high_seen = node_addr;
            end
            prev_node = node_addr;
         end
      end
      if (over || revisit) begin
         walk_phase = WALK_IDLE;
         queue_result(KIND_ABORT, 24'd0, 32'd0, 1'b1);
      end else begin
         walk_phase = WALK_HEADER;
         queue_result(KIND_READ, node_addr & WORD_ALIGN_MASK, 32'd0, 1'b1);
      end
   endtask

   task automatic leave_node();
      if (next_addr == END_MARK) begin
         walk_phase = WALK_IDLE;
         queue_result(KIND_DONE, 24'd0, 32'd0, 1'b1);
      end else begin
         node_addr = next_addr;
         visit_node();
      end
   endtask

   task automatic predict_walk_step(input logic action, input logic [23:0] start,
                                    input logic [31:0] word);
      if (action == ACTION_START) begin
         prev_node    = END_MARK;
         low_seen     = END_MARK;
         high_seen    = END_MARK;
         headers_done = 25'd0;
         words_left   = 8'd0;
         node_addr    = start;
         visit_node();
      end else begin
         case (walk_phase)
            WALK_HEADER: begin
               words_left   = word[31:24];
               next_addr    = word[23:0];
               payload_addr = node_addr + 24'd4;
               if (words_left != 8'd0) begin
                  walk_phase = WALK_PAYLOAD;
                  queue_result(KIND_READ, payload_addr & WORD_ALIGN_MASK, 32'd0, 1'b1);
               end else begin
                  leave_node();
               end
            end
            WALK_PAYLOAD: begin
               queue_result(KIND_GPU, 24'd0, word, 1'b0);
               words_left   = words_left - 8'd1;
               payload_addr = payload_addr + 24'd4;
               if (words_left != 8'd0) begin
                  queue_result(KIND_READ, payload_addr & WORD_ALIGN_MASK, 32'd0, 1'b1);
               end else begin
                  leave_node();
               end
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         walk_phase   = WALK_IDLE;
         packet_limit = MAX_PACKETS_RESET;
         node_addr    = 24'd0;
         next_addr    = 24'd0;
         payload_addr = 24'd0;
         words_left   = 8'd0;
         headers_done = 25'd0;
         prev_node    = END_MARK;
         low_seen     = END_MARK;
         high_seen    = END_MARK;
         walk_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (walk_results.size() == 0) begin
               $error("unexpected result transaction: kind %0d", rsp_tuser);
               fail_count++;
            end else begin
               wanted = walk_results.pop_front();
               if (rsp_tuser !== wanted.kind) begin
                  $error("kind: expected %0d, actual %0d", wanted.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[23:0] !== wanted.read_address) begin
                  $error("read_address: expected %h, actual %h",
                         wanted.read_address, rsp_tdata[23:0]);
                  fail_count++;
               end
               if (rsp_tdata[55:24] !== wanted.gpu_word) begin
                  $error("gpu_word: expected %h, actual %h",
                         wanted.gpu_word, rsp_tdata[55:24]);
                  fail_count++;
               end
               if (rsp_tlast !== wanted.last) begin
                  $error("last: expected %0d, actual %0d", wanted.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_walk_step(req_tuser, req_tdata[23:0], req_tdata[55:24]);
         end
         if (csr_wr_en) begin
            packet_limit = csr_wr_data;
         end
      end
      pending = walk_results.size();
   end

endmodule

[bench/testbench.sv]
module testbench;
   import lldw_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PHASE_ITEMS   = 75;
   localparam int PHASE_COUNT   = 6;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [23:0] csr_wr_data;

   logic        req_taken;
   int          fail_count;
   int          pending;
   int          cycle_count;
   int          items_sent;
   int          sender_idle_pct;
   int          receiver_stall_pct;

   linked_list_dma_walker_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   walk_checker walk_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Acceptance is captured at the rising edge and read back at the falling edge.
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic send_item(input logic action, input logic [23:0] start,
                            input logic [31:0] word);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {word, start};
      do @(negedge clock); while (!req_taken);
      items_sent++;
   endtask

   function automatic logic [23:0] pick_node_address();
      int r;
      r = $urandom_range(99);
      if (r < 8) begin
         return 24'hfffff0 + 24'($urandom_range(0, 12));
      end else if (r < 20) begin
         return 24'($urandom);
      end
      return 24'($urandom) & WORD_ALIGN_MASK;
   endfunction

   function automatic logic [7:0] pick_payload_count();
      int r;
      r = $urandom_range(99);
      if (r < 35) begin
         return 8'd0;
      end else if (r < 92) begin
         return 8'($urandom_range(1, 3));
      end else if (r < 99) begin
         return 8'($urandom_range(4, 16));
      end
      return 8'hff;
   endfunction

   // Mostly a well-formed list; some walks loop back to an earlier or the last node,
   // and some are dropped part-way so that the next start interrupts them.
   task automatic run_walk();
      logic [23:0] path[$];
      logic [23:0] next_hop;
      logic [7:0]  count;
      int          length;
      int          i;
      int          j;
      bit          looped;
      bit          abandoned;
      length    = $urandom_range(1, 5);
      looped    = ($urandom_range(99) < 15);
      abandoned = ($urandom_range(99) < 10);
      for (i = 0; i < length; i++) begin
         path.push_back(pick_node_address());
      end
      send_item(ACTION_START, path[0], $urandom);
      for (i = 0; i < length; i++) begin
         if (abandoned && $urandom_range(1) == 1) begin
            return;
         end
         if (i == length - 1) begin
            next_hop = looped ? path[$urandom_range(0, i)] : END_MARK;
         end else begin
            next_hop = path[i + 1];
         end
         count = pick_payload_count();
         send_item(ACTION_WORD, 24'($urandom), {count, next_hop});
         for (j = 0; j < count; j++) begin
            send_item(ACTION_WORD, 24'($urandom), $urandom);
         end
      end
      if (looped) begin
         send_item(ACTION_WORD, 24'($urandom), {8'd0, END_MARK});
      end
   endtask

   // A start at the end marker aborts at once, which leaves the walker idle.
   task automatic write_packet_limit(input logic [23:0] value);
      send_item(ACTION_START, END_MARK, $urandom);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [23:0] phase_limits[PHASE_COUNT];
      int          p;
      int          target;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      req_tuser          = ACTION_START;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      phase_limits[0] = 24'd1;
      phase_limits[1] = 24'hffffff;
      phase_limits[2] = 24'd2;
      phase_limits[3] = 24'd3;
      phase_limits[4] = 24'($urandom_range(1, 6));
      phase_limits[5] = MAX_PACKETS_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening under the reset packet limit.
      send_item(ACTION_WORD, 24'h5a5a5a, 32'hdeadbeef);
      send_item(ACTION_START, END_MARK, 32'h00000000);
      send_item(ACTION_START, 24'h000000, 32'hffffffff);
      send_item(ACTION_WORD, 24'hffffff, {8'd2, 24'hfffff8});
      send_item(ACTION_WORD, 24'h000000, 32'hffffffff);
      send_item(ACTION_WORD, 24'h000000, 32'h00000000);
      // The second node's payload address runs past the top of the address space.
      send_item(ACTION_WORD, 24'h000000, {8'd2, END_MARK});
      send_item(ACTION_WORD, 24'h000000, 32'ha5a5a5a5);
      send_item(ACTION_WORD, 24'h000000, 32'h5a5a5a5a);
      // Unaligned first node with an empty payload, then a full-count node cut short.
      send_item(ACTION_START, 24'h123457, 32'h12345678);
      send_item(ACTION_WORD, 24'h000000, {8'd0, 24'h000101});
      send_item(ACTION_WORD, 24'h000000, {8'hff, 24'h000200});
      send_item(ACTION_WORD, 24'h000000, 32'h0badf00d);
      send_item(ACTION_START, 24'h000100, 32'h00000000);
      send_item(ACTION_WORD, 24'h000000, {8'd0, 24'h000200});
      send_item(ACTION_WORD, 24'h000000, {8'd0, 24'h000100});
      send_item(ACTION_WORD, 24'h000000, 32'h87654321);

      items_sent = 0;
      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
            default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
         endcase
         write_packet_limit(phase_limits[p]);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(99) < 5) begin
               send_item(ACTION_WORD, 24'($urandom), $urandom);
            end else begin
               run_walk();
            end
         end
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
